/* rtl/core/volume_projection_connector_defines.svh */
// ----------------------------------------------------------------------------
// volume_projection_connector_defines
// Assertion macros for the connector RTL, used by the job queue.
// ----------------------------------------------------------------------------
`ifndef VOLUME_PROJECTION_CONNECTOR_DEFINES_SVH
`define VOLUME_PROJECTION_CONNECTOR_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define VPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/vpc_pkg.sv */
// ----------------------------------------------------------------------------
// vpc_pkg
// Shared widths, codes and types of the volume projection connector.
// ----------------------------------------------------------------------------
`default_nettype none

package vpc_pkg;

  localparam int COORD_BITS = 21;
  localparam int INDEX_BITS = 24;
  localparam int BOX_W      = 3 * COORD_BITS;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int MAG_W      = COORD_BITS + 1;
  localparam int SUM_W      = 2 * COORD_BITS + 3;
  // room for the squared distance times 10^12, kept even for the root
  localparam int ACC_W      = SUM_W + 41;
  localparam int ROOT_W     = ACC_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int SCALE_STEPS = 12;
  localparam int CNT_W      = $clog2(ROOT_W);
  localparam int VEL_W      = 24;
  localparam int DELAY_W    = 32;
  localparam int THR_W      = 17;
  localparam int DRAW_W     = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = BOX_W;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_LO    = 3'd0,
    CFG_SRC_HI    = 3'd1,
    CFG_DST_LO    = 3'd2,
    CFG_DST_HI    = 3'd3,
    CFG_THRESHOLD = 3'd4,
    CFG_DLY_MODE  = 3'd5,
    CFG_FIXED_DLY = 3'd6,
    CFG_VELOCITY  = 3'd7
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    DLY_ZERO   = 2'd0,
    DLY_FIXED  = 2'd1,
    DLY_RADIAL = 2'd2
  } dly_mode_e;

  typedef struct packed {
    logic [BOX_W-1:0]  src_lo;
    logic [BOX_W-1:0]  src_hi;
    logic [BOX_W-1:0]  dst_lo;
    logic [BOX_W-1:0]  dst_hi;
    logic [THR_W-1:0]  threshold;
  } front_cfg_t;

  typedef struct packed {
    dly_mode_e          mode;
    logic [DELAY_W-1:0] fixed_dly;
    logic [VEL_W-1:0]   velocity;
  } back_cfg_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]    pre_index;
    logic [INDEX_BITS-1:0]    post_index;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [DIFF_W-1:0] dz;
  } job_t;

  function automatic logic signed [COORD_BITS-1:0] box_axis(
    input logic [BOX_W-1:0] box,
    input int unsigned      k
  );
    box_axis = box[k*COORD_BITS +: COORD_BITS];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/vpc_front.sv */
// ----------------------------------------------------------------------------
// vpc_front
// Accepts items, tracks the armed generator, filters receivers by box and
// draw, and queues connection jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module vpc_front (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire vpc_pkg::front_cfg_t                    cfg_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic                                   req_type_i,
  input  wire logic signed [vpc_pkg::COORD_BITS-1:0]  pos_x_i,
  input  wire logic signed [vpc_pkg::COORD_BITS-1:0]  pos_y_i,
  input  wire logic signed [vpc_pkg::COORD_BITS-1:0]  pos_z_i,
  input  wire logic                                   coord_valid_i,
  input  wire logic [vpc_pkg::INDEX_BITS-1:0]         member_index_i,
  input  wire logic [vpc_pkg::DRAW_W-1:0]             random_draw_i,
  input  wire logic                                   fifo_full_i,
  output logic                                        push_o,
  output vpc_pkg::job_t                               job_o
);

  logic                              gen_active_q, gen_active_d;
  logic [vpc_pkg::BOX_W-1:0]         gen_pos_q, gen_pos_d;
  logic [vpc_pkg::INDEX_BITS-1:0]    gen_idx_q, gen_idx_d;

  logic                                     accept;
  logic [vpc_pkg::BOX_W-1:0]                pos_packed;
  logic signed [vpc_pkg::COORD_BITS-1:0]    pos_a [3];
  logic signed [vpc_pkg::DIFF_W-1:0]        diff_a [3];
  logic                                     src_in, dst_in, draw_ok;

  assign in_stall_o = fifo_full_i;
  assign accept     = in_valid_i && !fifo_full_i;
  assign pos_packed = {pos_z_i, pos_y_i, pos_x_i};
  assign pos_a[0]   = pos_x_i;
  assign pos_a[1]   = pos_y_i;
  assign pos_a[2]   = pos_z_i;
  assign draw_ok    = {1'b0, random_draw_i} < cfg_i.threshold;

  always_comb begin
    src_in = 1'b1;
    dst_in = 1'b1;
    for (int k = 0; k < 3; k++) begin
      diff_a[k] = vpc_pkg::DIFF_W'(pos_a[k])
                - vpc_pkg::DIFF_W'(vpc_pkg::box_axis(gen_pos_q, k));
      if (!(vpc_pkg::box_axis(cfg_i.src_lo, k) < pos_a[k] &&
            pos_a[k] <= vpc_pkg::box_axis(cfg_i.src_hi, k))) begin
        src_in = 1'b0;
      end
      if (!(vpc_pkg::DIFF_W'(vpc_pkg::box_axis(cfg_i.dst_lo, k)) < diff_a[k] &&
            diff_a[k] <= vpc_pkg::DIFF_W'(vpc_pkg::box_axis(cfg_i.dst_hi, k)))) begin
        dst_in = 1'b0;
      end
    end
  end

  always_comb begin
    gen_active_d = gen_active_q;
    gen_pos_d    = gen_pos_q;
    gen_idx_d    = gen_idx_q;
    if (accept && !req_type_i) begin
      if (!coord_valid_i) begin
        gen_active_d = 1'b0;
      end else begin
        gen_pos_d    = pos_packed;
        gen_idx_d    = member_index_i;
        gen_active_d = src_in;
      end
    end
  end

  assign push_o = accept && req_type_i && coord_valid_i && gen_active_q && dst_in && draw_ok;

  always_comb begin
    job_o.pre_index  = gen_idx_q;
    job_o.post_index = member_index_i;
    job_o.dx         = diff_a[0];
    job_o.dy         = diff_a[1];
    job_o.dz         = diff_a[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_active_q <= 1'b0;
      gen_pos_q    <= '0;
      gen_idx_q    <= '0;
    end else begin
      gen_active_q <= gen_active_d;
      gen_pos_q    <= gen_pos_d;
      gen_idx_q    <= gen_idx_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/vpc_fifo.sv */
// ----------------------------------------------------------------------------
// vpc_fifo
// Short job queue between the front filter and the delay unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "volume_projection_connector_defines.svh"

module vpc_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire vpc_pkg::job_t push_data_i,
  input  wire logic          pop_i,
  output vpc_pkg::job_t      pop_data_o,
  output logic               full_o,
  output logic               empty_o
);

  vpc_pkg::job_t                   mem_q [vpc_pkg::FIFO_DEPTH];
  logic [vpc_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [vpc_pkg::FIFO_CNT_W-1:0]  count_q;

  assign full_o     = count_q == vpc_pkg::FIFO_CNT_W'(vpc_pkg::FIFO_DEPTH);
  assign empty_o    = count_q == '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `VPC_ASSERT_IMPL(a_no_push_full, push_i, !full_o, "job pushed into full queue")
  `VPC_ASSERT_IMPL(a_no_pop_empty, pop_i, !empty_o, "job popped from empty queue")
  `VPC_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + 1'b1,
                   "queue count did not advance on push")

endmodule

`default_nettype wire

/* rtl/core/vpc_back.sv */
// ----------------------------------------------------------------------------
// vpc_back
// Delay unit: zero or fixed delay, or radial: squared distance, scale by 10^12,
// bitwise square root, restoring division by velocity; then the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vpc_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire vpc_pkg::back_cfg_t                  cfg_i,
  input  wire logic                                fifo_empty_i,
  input  wire vpc_pkg::job_t                       job_i,
  output logic                                     pop_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [vpc_pkg::INDEX_BITS-1:0]           pre_index_o,
  output logic [vpc_pkg::INDEX_BITS-1:0]           post_index_o,
  output logic [vpc_pkg::DELAY_W-1:0]              delay_ns_o
);

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQ,
    B_SCALE,
    B_SQRT,
    B_DIV,
    B_DONE
  } back_state_e;

  back_state_e                      state_q;
  logic [vpc_pkg::INDEX_BITS-1:0]   pre_q, post_q;
  logic [vpc_pkg::MAG_W-1:0]        mag_q [3];
  logic [vpc_pkg::CNT_W-1:0]        cnt_q;
  logic [vpc_pkg::ACC_W-1:0]        acc_q;
  logic [vpc_pkg::REM_W-1:0]        rem_q;
  logic [vpc_pkg::ROOT_W-1:0]       root_q;
  logic [vpc_pkg::VEL_W:0]          rdiv_q;
  logic [vpc_pkg::DELAY_W-1:0]      delay_q;
  logic                             out_valid_q;
  logic [vpc_pkg::INDEX_BITS-1:0]   out_pre_q, out_post_q;
  logic [vpc_pkg::DELAY_W-1:0]      out_delay_q;

  logic signed [vpc_pkg::DIFF_W-1:0] job_d [3];
  logic [vpc_pkg::MAG_W-1:0]         job_mag [3];
  logic [2*vpc_pkg::MAG_W-1:0]       sq;
  logic [vpc_pkg::REM_W-1:0]         rem_sh, trial;
  logic [vpc_pkg::VEL_W:0]           rdiv_sh;
  logic                              div_ge;
  logic                              out_free;

  assign job_d[0] = job_i.dx;
  assign job_d[1] = job_i.dy;
  assign job_d[2] = job_i.dz;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      job_mag[k] = job_d[k][vpc_pkg::DIFF_W-1] ? vpc_pkg::MAG_W'(-job_d[k])
                                                : vpc_pkg::MAG_W'(job_d[k]);
    end
  end

  assign sq      = mag_q[0] * mag_q[0];
  assign rem_sh  = {rem_q[vpc_pkg::REM_W-3:0], acc_q[vpc_pkg::ACC_W-1 -: 2]};
  assign trial   = vpc_pkg::REM_W'({root_q, 2'b01});
  assign rdiv_sh = {rdiv_q[vpc_pkg::VEL_W-1:0], root_q[vpc_pkg::ROOT_W-1]};
  assign div_ge  = rdiv_sh >= {1'b0, cfg_i.velocity};

  assign pop_o       = state_q == B_IDLE && !fifo_empty_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign pre_index_o  = out_pre_q;
  assign post_index_o = out_post_q;
  assign delay_ns_o   = out_delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      pre_q       <= '0;
      post_q      <= '0;
      mag_q       <= '{default: '0};
      acc_q       <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      rdiv_q      <= '0;
      delay_q     <= '0;
      out_pre_q   <= '0;
      out_post_q  <= '0;
      out_delay_q <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        B_IDLE: begin
          if (!fifo_empty_i) begin
            pre_q  <= job_i.pre_index;
            post_q <= job_i.post_index;
            mag_q  <= job_mag;
            acc_q  <= '0;
            cnt_q  <= '0;
            priority case (cfg_i.mode)
              vpc_pkg::DLY_FIXED: begin
                delay_q <= cfg_i.fixed_dly;
                state_q <= B_DONE;
              end
              vpc_pkg::DLY_RADIAL: begin
                if (cfg_i.velocity == '0) begin
                  delay_q <= '1;
                  state_q <= B_DONE;
                end else begin
                  state_q <= B_SQ;
                end
              end
              default: begin
                delay_q <= '0;
                state_q <= B_DONE;
              end
            endcase
          end
        end
        B_SQ: begin
          acc_q    <= acc_q + vpc_pkg::ACC_W'(sq);
          mag_q[0] <= mag_q[1];
          mag_q[1] <= mag_q[2];
          cnt_q    <= cnt_q + 1'b1;
          if (cnt_q == vpc_pkg::CNT_W'(2)) begin
            cnt_q   <= '0;
            state_q <= B_SCALE;
          end
        end
        B_SCALE: begin
          // times ten per cycle
          acc_q <= (acc_q << 3) + (acc_q << 1);
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == vpc_pkg::CNT_W'(vpc_pkg::SCALE_STEPS - 1)) begin
            cnt_q   <= '0;
            rem_q   <= '0;
            root_q  <= '0;
            state_q <= B_SQRT;
          end
        end
        B_SQRT: begin
          acc_q <= acc_q << 2;
          if (rem_sh >= trial) begin
            rem_q  <= rem_sh - trial;
            root_q <= {root_q[vpc_pkg::ROOT_W-2:0], 1'b1};
          end else begin
            rem_q  <= rem_sh;
            root_q <= {root_q[vpc_pkg::ROOT_W-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == vpc_pkg::CNT_W'(vpc_pkg::ROOT_W - 1)) begin
            cnt_q   <= '0;
            rdiv_q  <= '0;
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          // shift quotient bits in behind the root
          rdiv_q <= div_ge ? rdiv_sh - {1'b0, cfg_i.velocity} : rdiv_sh;
          root_q <= {root_q[vpc_pkg::ROOT_W-2:0], div_ge};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == vpc_pkg::CNT_W'(vpc_pkg::ROOT_W - 1)) begin
            cnt_q   <= '0;
            state_q <= B_DONE;
            if (|root_q[vpc_pkg::ROOT_W-2:vpc_pkg::DELAY_W-1]) begin
              delay_q <= '1;
            end else begin
              delay_q <= {root_q[vpc_pkg::DELAY_W-2:0], div_ge};
            end
          end
        end
        B_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_pre_q   <= pre_q;
            out_post_q  <= post_q;
            out_delay_q <= delay_q;
            state_q     <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/volume_projection_connector.sv */
// In zero and fixed delay modes an item passes the job queue, then the done
// state of the delay unit and the result register; radial mode adds squaring,
// scaling, and the serial square root and divider, one bit per cycle each.
// Throughput: one item per cycle while the 2-deep job queue has room; the
// delay unit finishes one connection at a time.
// Reset: asynchronous, active low; clears generator state, queue and outputs.
// ----------------------------------------------------------------------------
// volume_projection_connector
// Top level: configuration registers, front filter, job queue, delay unit.
// ----------------------------------------------------------------------------
`default_nettype none

module volume_projection_connector (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [vpc_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [vpc_pkg::CFG_DATA_W-1:0]         cfg_wdata_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic                                   req_type_i,
  input  wire logic signed [vpc_pkg::COORD_BITS-1:0]  pos_x_i,
  input  wire logic signed [vpc_pkg::COORD_BITS-1:0]  pos_y_i,
  input  wire logic signed [vpc_pkg::COORD_BITS-1:0]  pos_z_i,
  input  wire logic                                   coord_valid_i,
  input  wire logic [vpc_pkg::INDEX_BITS-1:0]         member_index_i,
  input  wire logic [vpc_pkg::DRAW_W-1:0]             random_draw_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic [vpc_pkg::INDEX_BITS-1:0]              pre_index_o,
  output logic [vpc_pkg::INDEX_BITS-1:0]              post_index_o,
  output logic [vpc_pkg::DELAY_W-1:0]                 delay_ns_o
);

  logic [vpc_pkg::BOX_W-1:0]   src_lo_q, src_hi_q, dst_lo_q, dst_hi_q;
  logic [vpc_pkg::THR_W-1:0]   thr_q;
  logic [vpc_pkg::MODE_W-1:0]  mode_q;
  logic [vpc_pkg::DELAY_W-1:0] fixed_q;
  logic [vpc_pkg::VEL_W-1:0]   vel_q;

  vpc_pkg::front_cfg_t front_cfg;
  vpc_pkg::back_cfg_t  back_cfg;
  vpc_pkg::job_t       push_job, pop_job;
  logic                push, pop, fifo_full, fifo_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_lo_q <= '0;
      src_hi_q <= '0;
      dst_lo_q <= '0;
      dst_hi_q <= '0;
      thr_q    <= vpc_pkg::THR_W'(65536);
      mode_q   <= vpc_pkg::DLY_ZERO;
      fixed_q  <= '0;
      vel_q    <= vpc_pkg::VEL_W'(1000);
    end else if (cfg_we_i) begin
      unique case (vpc_pkg::cfg_idx_e'(cfg_idx_i))
        vpc_pkg::CFG_SRC_LO:    src_lo_q <= cfg_wdata_i[vpc_pkg::BOX_W-1:0];
        vpc_pkg::CFG_SRC_HI:    src_hi_q <= cfg_wdata_i[vpc_pkg::BOX_W-1:0];
        vpc_pkg::CFG_DST_LO:    dst_lo_q <= cfg_wdata_i[vpc_pkg::BOX_W-1:0];
        vpc_pkg::CFG_DST_HI:    dst_hi_q <= cfg_wdata_i[vpc_pkg::BOX_W-1:0];
        vpc_pkg::CFG_THRESHOLD: thr_q    <= cfg_wdata_i[vpc_pkg::THR_W-1:0];
        vpc_pkg::CFG_DLY_MODE:  mode_q   <= cfg_wdata_i[vpc_pkg::MODE_W-1:0];
        vpc_pkg::CFG_FIXED_DLY: fixed_q  <= cfg_wdata_i[vpc_pkg::DELAY_W-1:0];
        vpc_pkg::CFG_VELOCITY:  vel_q    <= cfg_wdata_i[vpc_pkg::VEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    front_cfg.src_lo    = src_lo_q;
    front_cfg.src_hi    = src_hi_q;
    front_cfg.dst_lo    = dst_lo_q;
    front_cfg.dst_hi    = dst_hi_q;
    front_cfg.threshold = thr_q;
    back_cfg.mode       = vpc_pkg::dly_mode_e'(mode_q);
    back_cfg.fixed_dly  = fixed_q;
    back_cfg.velocity   = vel_q;
  end

  vpc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (front_cfg),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .coord_valid_i  (coord_valid_i),
    .member_index_i (member_index_i),
    .random_draw_i  (random_draw_i),
    .fifo_full_i    (fifo_full),
    .push_o         (push),
    .job_o          (push_job)
  );

  vpc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty)
  );

  vpc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (back_cfg),
    .fifo_empty_i (fifo_empty),
    .job_i        (pop_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pre_index_o  (pre_index_o),
    .post_index_o (post_index_o),
    .delay_ns_o   (delay_ns_o)
  );

endmodule

`default_nettype wire
